// ===== rtl/iedec_pkg.sv =====
// Shared types, character codes and decode functions for the escape decoder.
package iedec_pkg;

    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_K     = 8'h4B;
    localparam logic [7:0] CH_L     = 8'h4C;
    localparam logic [7:0] CH_M     = 8'h4D;
    localparam logic [7:0] CH_N     = 8'h4E;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_Q     = 8'h51;
    localparam logic [7:0] CH_R     = 8'h52;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_U     = 8'h55;
    localparam logic [7:0] CH_LBRK  = 8'h5B;
    localparam logic [7:0] CH_RBRK  = 8'h5D;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_CARET = 8'h5E;
    localparam logic [7:0] CH_QUEST = 8'h3F;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_QUOTE = 8'h27;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;

    localparam int QDEPTH = 2;
    localparam int QAW    = 1;
    localparam int QCW    = 2;

    // up to three output bytes for one input item
    typedef struct packed {
        logic [1:0]      cnt;
        logic [2:0][7:0] bytes;
        logic            name_end;
    } iedec_cmd_t;

    typedef struct packed {
        logic       valid;
        iedec_cmd_t cmd;
    } iedec_q_t;

    typedef struct packed {
        logic [1:0] len;
        logic [7:0] c0;
        logic [7:0] c1;
    } iedec_esc_t;

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= CH_0 && c <= CH_9) || (c >= CH_LA && c <= CH_LF) ||
               (c >= CH_UA && c <= CH_UF);
    endfunction

    function automatic logic [3:0] hex_nibble(input logic [7:0] c);
        logic [7:0] v;
        v = c - CH_0;
        if (c >= CH_LA) begin
            v = c - CH_LA + 8'd10;
        end else if (c >= CH_UA) begin
            v = c - CH_UA + 8'd10;
        end
        return v[3:0];
    endfunction

    function automatic iedec_esc_t esc_map(input logic [7:0] c);
        iedec_esc_t e;
        e = '{len: 2'd1, c0: 8'h00, c1: 8'h00};
        unique case (c)
            CH_UNDER: e.c0 = CH_UNDER;
            CH_K: begin
                e.len = 2'd2;
                e.c0  = CH_LBRK;
                e.c1  = CH_RBRK;
            end
            CH_L: e.c0 = CH_LPAR;
            CH_M: e.c0 = CH_COMMA;
            CH_N: e.c0 = CH_COLON;
            CH_P: e.c0 = CH_CARET;
            CH_Q: e.c0 = CH_QUEST;
            CH_R: e.c0 = CH_RPAR;
            CH_T: begin
                e.len = 2'd2;
                e.c0  = CH_DASH;
                e.c1  = CH_GT;
            end
            CH_U: e.c0 = CH_QUOTE;
            default: e.len = 2'd0;
        endcase
        return e;
    endfunction

endpackage

// ===== rtl/iedec_front.sv =====
// Front end: accepts input items, tracks pending escape state, builds byte commands.
module iedec_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                accept,
    input  logic [7:0]          in_byte,
    input  logic                name_end,
    output logic                push,
    output iedec_pkg::iedec_cmd_t cmd
);
    import iedec_pkg::*;

    typedef enum logic [1:0] {
        P_NONE,
        P_UNDER,
        P_LETTER
    } pend_t;

    pend_t      state_reg, state_next;
    logic [7:0] letter_reg, letter_next;
    iedec_esc_t esc;
    logic       emit;

    always_comb begin
        esc         = esc_map(in_byte);
        state_next  = state_reg;
        letter_next = letter_reg;
        emit        = 1'b0;
        cmd.cnt      = 2'd1;
        cmd.bytes    = {8'h00, 8'h00, in_byte};
        cmd.name_end = name_end;
        unique case (state_reg)
            P_UNDER: begin
                if (esc.len != 2'd0) begin
                    emit       = 1'b1;
                    cmd.cnt    = esc.len;
                    cmd.bytes  = {8'h00, esc.c1, esc.c0};
                    state_next = P_NONE;
                end else if (name_end) begin
                    emit       = 1'b1;
                    cmd.cnt    = 2'd2;
                    cmd.bytes  = {8'h00, in_byte, CH_UNDER};
                    state_next = P_NONE;
                end else begin
                    letter_next = in_byte;
                    state_next  = P_LETTER;
                end
            end
            P_LETTER: begin
                emit       = 1'b1;
                state_next = P_NONE;
                if (is_hex(letter_reg) && is_hex(in_byte)) begin
                    cmd.cnt   = 2'd1;
                    cmd.bytes = {8'h00, 8'h00, hex_nibble(letter_reg), hex_nibble(in_byte)};
                end else begin
                    cmd.cnt   = 2'd3;
                    cmd.bytes = {in_byte, letter_reg, CH_UNDER};
                end
            end
            default: begin
                if (in_byte != CH_UNDER || name_end) begin
                    emit       = 1'b1;
                    state_next = P_NONE;
                end else begin
                    state_next = P_UNDER;
                end
            end
        endcase
    end

    assign push = accept && emit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= P_NONE;
            letter_reg <= 8'h00;
        end else if (accept) begin
            state_reg  <= state_next;
            letter_reg <= letter_next;
        end
    end

endmodule

// ===== rtl/iedec_fifo.sv =====
// Two-entry command queue between the front end and the output sequencer.
module iedec_fifo (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  iedec_pkg::iedec_cmd_t push_cmd,
    input  logic                  pop,
    output iedec_pkg::iedec_q_t   head,
    output logic                  full
);
    import iedec_pkg::*;

    iedec_cmd_t       mem [QDEPTH];
    logic [QAW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QCW-1:0]   count_reg, count_next;

    assign full       = (count_reg == QCW'(QDEPTH));
    assign head.valid = (count_reg != '0);
    assign head.cmd   = mem[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + QCW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - QCW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

endmodule

// ===== rtl/iedec_back.sv =====
// Back end: expands queued commands into one output item per cycle while m_tready is high.
module iedec_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  iedec_pkg::iedec_q_t head,
    output logic                pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [7:0]          m_tdata,
    output logic                m_tlast,
    output logic                m_tuser
);
    import iedec_pkg::*;

    iedec_cmd_t cmd_reg, cmd_next;
    logic [1:0] idx_reg, idx_next;
    logic       busy_reg, busy_next;
    logic       valid_reg, valid_next;
    logic [7:0] data_reg, data_next;
    logic       last_reg, last_next;
    logic       user_reg, user_next;

    iedec_cmd_t src;
    logic [1:0] src_idx;
    logic       have, out_free, fin;

    always_comb begin
        src      = busy_reg ? cmd_reg : head.cmd;
        src_idx  = busy_reg ? idx_reg : 2'd0;
        have     = busy_reg || head.valid;
        out_free = !valid_reg || m_tready;
        fin      = (src_idx == src.cnt - 2'd1);
        pop      = out_free && !busy_reg && head.valid;

        cmd_next   = cmd_reg;
        idx_next   = idx_reg;
        busy_next  = busy_reg;
        valid_next = valid_reg && !m_tready;
        data_next  = data_reg;
        last_next  = last_reg;
        user_next  = user_reg;
        if (out_free && have) begin
            valid_next = 1'b1;
            data_next  = src.bytes[src_idx];
            last_next  = fin;
            user_next  = fin && src.name_end;
            busy_next  = !fin;
            cmd_next   = src;
            idx_next   = src_idx + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            busy_reg  <= busy_next;
            valid_reg <= valid_next;
        end
        cmd_reg  <= cmd_next;
        idx_reg  <= idx_next;
        data_reg <= data_next;
        last_reg <= last_next;
        user_reg <= user_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;
    assign m_tuser  = user_reg;

endmodule

// ===== rtl/identifier_escape_decoder.sv =====
// Top level of the escaped identifier decoder.
// Decodes an escaped name arriving one byte per input item (s_tlast on the final byte) and
// returns the unescaped bytes, one per output item; m_tlast marks the last byte caused by an
// input item and m_tuser the final byte of the name. Plain bytes and hex or letter escapes
// that give one byte keep a rate of one item per cycle while m_tready is high; an escape
// that expands to two or three bytes holds the output sequencer while it sends them,
// and the two-entry command queue absorbs it before s_tready drops.
module identifier_escape_decoder (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,   // name_end
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast,   // run_last
    output logic       m_tuser    // [0] out_end
);
    import iedec_pkg::*;

    logic       accept, push, pop, full;
    iedec_cmd_t cmd;
    iedec_q_t   head;

    assign s_tready = !full;
    assign accept   = s_tvalid && s_tready;

    iedec_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .accept   (accept),
        .in_byte  (s_tdata),
        .name_end (s_tlast),
        .push     (push),
        .cmd      (cmd)
    );

    iedec_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (cmd),
        .pop      (pop),
        .head     (head),
        .full     (full)
    );

    iedec_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

// ===== rtl/iedec_checker.sv =====
// Port-level checks for the escaped identifier decoder, bound to the top level.
module iedec_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast,
    input logic       m_tuser
);

    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    a_ready_after_reset: assert property (@(posedge aclk) $rose(aresetn) |-> s_tready)
        else $error("input not ready after reset");

    a_end_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("name end on a byte that is not last of its run");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
            && $stable(m_tuser))
        else $error("stalled output item changed");

endmodule

bind identifier_escape_decoder iedec_checker u_iedec_checker (.*);
